// ----- rtl/core/qdf_pkg.sv -----
`default_nettype none

package qdf_pkg;

    localparam int VEL_WIDTH_DEF = 16;
    localparam int CFG_W         = 16;
    localparam int COEFF_W       = 16;
    localparam int GAIN_W        = 32;
    localparam int FORCE_W       = 32;
    localparam int FRAC_SHIFT    = 24;
    localparam int CFG_INDEX_W   = 8;
    // must be a power of two: pointers wrap naturally
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_W-1:0] DRAG_STRENGTH_RST = 16'd256;
    localparam logic [CFG_W-1:0] MIN_SPEED_RST     = 16'd1;

    localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0] FORCE_NEG_MIN = 32'h8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DRAG_STRENGTH = 8'd0,
        REG_MIN_SPEED     = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] drag_strength;
        logic [CFG_W-1:0] min_speed;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/quadratic_drag_force.sv -----
// Channel | Direction | Handshake              | Payload
// cell    | in        | cell_valid/cell_stall  | cell_empty cell_wall vel_x vel_y drag_coeff
// force   | out       | force_valid/force_stall| force_x force_y
// cfg     | in        | cfg_valid/cfg_ready    | cfg_index cfg_data
//
// One cell transaction per cycle while cell_stall is low; the square root resolves
// one bit per pipeline stage.
// Reset (rst_n low) empties the pipeline and loads drag_strength 1.0, min_speed 1.
// A force stall freezes the back pipeline; the two-entry queue and front register
// keep taking cells until both are full, then cell_stall rises.
`default_nettype none

module quadratic_drag_force #(
    parameter int VEL_WIDTH = qdf_pkg::VEL_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cell_valid,
    output logic                                   cell_stall,
    input  wire logic                              cell_empty,
    input  wire logic                              cell_wall,
    input  wire logic signed [VEL_WIDTH-1:0]       vel_x,
    input  wire logic signed [VEL_WIDTH-1:0]       vel_y,
    input  wire logic [qdf_pkg::COEFF_W-1:0]       drag_coeff,
    output logic                                   force_valid,
    input  wire logic                              force_stall,
    output logic signed [qdf_pkg::FORCE_W-1:0]     force_x,
    output logic signed [qdf_pkg::FORCE_W-1:0]     force_y,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [qdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [qdf_pkg::CFG_W-1:0]         cfg_data
);

    localparam int ITEM_W = 3 + 2 * VEL_WIDTH + qdf_pkg::GAIN_W;

    qdf_pkg::cfg_t     cfg_reg;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    logic [ITEM_W-1:0] q_in;
    logic [ITEM_W-1:0] q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drag_strength <= qdf_pkg::DRAG_STRENGTH_RST;
            cfg_reg.min_speed     <= qdf_pkg::MIN_SPEED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (qdf_pkg::cfg_reg_t'(cfg_index))
                qdf_pkg::REG_DRAG_STRENGTH: cfg_reg.drag_strength <= cfg_data;
                qdf_pkg::REG_MIN_SPEED:     cfg_reg.min_speed     <= cfg_data;
                default: ;
            endcase
        end
    end

    qdf_front #(
        .VEL_WIDTH (VEL_WIDTH),
        .ITEM_W    (ITEM_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_empty (cell_empty),
        .cell_wall  (cell_wall),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .drag_coeff (drag_coeff),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    qdf_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    qdf_back #(
        .VEL_WIDTH (VEL_WIDTH),
        .ITEM_W    (ITEM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .cfg         (cfg_reg),
        .force_valid (force_valid),
        .force_stall (force_stall),
        .force_x     (force_x),
        .force_y     (force_y)
    );

endmodule

`default_nettype wire

// ----- rtl/core/qdf_front.sv -----
`default_nettype none

module qdf_front #(
    parameter int VEL_WIDTH = qdf_pkg::VEL_WIDTH_DEF,
    parameter int ITEM_W    = 3 + 2 * VEL_WIDTH + qdf_pkg::GAIN_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cell_valid,
    output logic                               cell_stall,
    input  wire logic                          cell_empty,
    input  wire logic                          cell_wall,
    input  wire logic signed [VEL_WIDTH-1:0]   vel_x,
    input  wire logic signed [VEL_WIDTH-1:0]   vel_y,
    input  wire logic [qdf_pkg::COEFF_W-1:0]   drag_coeff,
    input  wire qdf_pkg::cfg_t                 cfg,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [ITEM_W-1:0]                  q_data
);

    logic                         valid_reg;
    logic                         valid_next;
    logic                         zero_reg;
    logic                         nx_reg;
    logic                         ny_reg;
    logic [VEL_WIDTH-1:0]         ax_reg;
    logic [VEL_WIDTH-1:0]         ay_reg;
    logic [qdf_pkg::GAIN_W-1:0]   gain_reg;
    logic [VEL_WIDTH-1:0]         vx_u;
    logic [VEL_WIDTH-1:0]         vy_u;
    logic [VEL_WIDTH-1:0]         ax_c;
    logic [VEL_WIDTH-1:0]         ay_c;
    logic                         accept;

    assign vx_u = vel_x;
    assign vy_u = vel_y;
    assign ax_c = vx_u[VEL_WIDTH-1] ? (~vx_u + {{(VEL_WIDTH-1){1'b0}}, 1'b1}) : vx_u;
    assign ay_c = vy_u[VEL_WIDTH-1] ? (~vy_u + {{(VEL_WIDTH-1){1'b0}}, 1'b1}) : vy_u;

    assign cell_stall = valid_reg && q_full;
    assign accept     = cell_valid && !cell_stall;
    assign q_push     = valid_reg && !q_full;
    assign q_data     = {zero_reg, nx_reg, ny_reg, ax_reg, ay_reg, gain_reg};

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zero_reg <= cell_empty | cell_wall;
            nx_reg   <= vx_u[VEL_WIDTH-1];
            ny_reg   <= vy_u[VEL_WIDTH-1];
            ax_reg   <= ax_c;
            ay_reg   <= ay_c;
            gain_reg <= qdf_pkg::GAIN_W'(cfg.drag_strength) * qdf_pkg::GAIN_W'(drag_coeff);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qdf_queue.sv -----
`default_nettype none

module qdf_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      head
);

    localparam int DEPTH = qdf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qdf_back.sv -----
`default_nettype none

module qdf_back #(
    parameter int VEL_WIDTH = qdf_pkg::VEL_WIDTH_DEF,
    parameter int ITEM_W    = 3 + 2 * VEL_WIDTH + qdf_pkg::GAIN_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire logic [ITEM_W-1:0]             q_data,
    output logic                               q_pop,
    input  wire qdf_pkg::cfg_t                 cfg,
    output logic                               force_valid,
    input  wire logic                          force_stall,
    output logic signed [qdf_pkg::FORCE_W-1:0] force_x,
    output logic signed [qdf_pkg::FORCE_W-1:0] force_y
);

    localparam int W     = VEL_WIDTH;
    localparam int SQ_W  = 2 * W;
    localparam int CMP_W = (SQ_W > 2 * qdf_pkg::CFG_W) ? SQ_W : 2 * qdf_pkg::CFG_W;
    localparam int GW    = qdf_pkg::GAIN_W;
    localparam int PX_W  = GW + W;
    localparam int P_W   = GW + SQ_W;
    localparam int M_W   = P_W - qdf_pkg::FRAC_SHIFT;
    localparam int MX_W  = (M_W > qdf_pkg::FORCE_W + 1) ? M_W : qdf_pkg::FORCE_W + 1;

    // saturate a magnitude and apply the sign opposite to the velocity
    function automatic logic [qdf_pkg::FORCE_W-1:0] sat_force(
        input logic [MX_W-1:0] m,
        input logic            vel_neg
    );
        logic [qdf_pkg::FORCE_W-1:0] r;
        if (vel_neg)
        begin
            r = (m > MX_W'(qdf_pkg::FORCE_POS_MAX)) ? qdf_pkg::FORCE_POS_MAX
                                                    : m[qdf_pkg::FORCE_W-1:0];
        end
        else
        begin
            r = (m > MX_W'(qdf_pkg::FORCE_NEG_MIN)) ? qdf_pkg::FORCE_NEG_MIN
                                                    : (~m[qdf_pkg::FORCE_W-1:0] + 32'd1);
        end
        return r;
    endfunction

    logic en;

    assign en    = !force_valid || !force_stall;
    assign q_pop = en && !q_empty;

    // stage 0: squares
    logic                   s0_valid_reg;
    logic [ITEM_W-1:0]      s0_item_reg;
    logic [SQ_W-1:0]        s0_sqx_reg;
    logic [SQ_W-1:0]        s0_sqy_reg;
    logic [2*qdf_pkg::CFG_W-1:0] s0_minsq_reg;
    logic [W-1:0]           q_ax;
    logic [W-1:0]           q_ay;

    assign q_ax = q_data[GW+W +: W];
    assign q_ay = q_data[GW +: W];

    // stage 1: sum and speed test
    logic                   s1_valid_reg;
    logic [ITEM_W-1:0]      s1_item_reg;
    logic [SQ_W-1:0]        s1_mag2_reg;
    logic [SQ_W-1:0]        mag2_c;
    logic                   below_c;

    assign mag2_c  = s0_sqx_reg + s0_sqy_reg;
    assign below_c = CMP_W'(mag2_c) < CMP_W'(s0_minsq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= q_pop;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg  <= q_data;
            s0_sqx_reg   <= SQ_W'(q_ax) * SQ_W'(q_ay - q_ay + q_ax);
            s0_sqy_reg   <= SQ_W'(q_ay) * SQ_W'(q_ay);
            s0_minsq_reg <= (2*qdf_pkg::CFG_W)'(cfg.min_speed)
                            * (2*qdf_pkg::CFG_W)'(cfg.min_speed);
            s1_item_reg  <= {s0_item_reg[ITEM_W-1] | below_c, s0_item_reg[ITEM_W-2:0]};
            s1_mag2_reg  <= mag2_c;
        end
    end

    // square root, one result bit per stage
    logic              rv_c   [W+1];
    logic [SQ_W-1:0]   rem_c  [W+1];
    logic [SQ_W-1:0]   res_c  [W+1];
    logic [ITEM_W-1:0] item_c [W+1];

    assign rv_c[0]   = s1_valid_reg;
    assign rem_c[0]  = s1_mag2_reg;
    assign res_c[0]  = '0;
    assign item_c[0] = s1_item_reg;

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (W - 1 - k));

        logic              v_reg;
        logic [SQ_W-1:0]   rem_reg;
        logic [SQ_W-1:0]   res_reg;
        logic [ITEM_W-1:0] item_reg;
        logic [SQ_W:0]     trial;
        logic              ge;

        assign trial = {1'b0, res_c[k]} + {1'b0, BIT};
        assign ge    = {1'b0, rem_c[k]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= rv_c[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg <= item_c[k];
                rem_reg  <= ge ? (rem_c[k] - trial[SQ_W-1:0]) : rem_c[k];
                res_reg  <= ge ? ((res_c[k] >> 1) + BIT) : (res_c[k] >> 1);
            end
        end

        assign rv_c[k+1]   = v_reg;
        assign rem_c[k+1]  = rem_reg;
        assign res_c[k+1]  = res_reg;
        assign item_c[k+1] = item_reg;
    end

    // multiply stages
    logic [ITEM_W-1:0] fin_item;
    logic [W-1:0]      mag;

    assign fin_item = item_c[W];
    assign mag      = res_c[W][W-1:0];

    logic              m1_valid_reg;
    logic [2:0]        m1_flags_reg;
    logic [W-1:0]      m1_mag_reg;
    logic [PX_W-1:0]   m1_px_reg;
    logic [PX_W-1:0]   m1_py_reg;

    logic              m2_valid_reg;
    logic [2:0]        m2_flags_reg;
    logic [PX_W-1:0]   m2_xlo_reg;
    logic [SQ_W-1:0]   m2_xhi_reg;
    logic [PX_W-1:0]   m2_ylo_reg;
    logic [SQ_W-1:0]   m2_yhi_reg;

    logic                        force_valid_reg;
    logic [qdf_pkg::FORCE_W-1:0] force_x_reg;
    logic [qdf_pkg::FORCE_W-1:0] force_y_reg;

    logic [P_W-1:0]    full_x;
    logic [P_W-1:0]    full_y;
    logic [MX_W-1:0]   mag_x;
    logic [MX_W-1:0]   mag_y;

    assign full_x = P_W'(m2_xlo_reg) + (P_W'(m2_xhi_reg) << GW);
    assign full_y = P_W'(m2_ylo_reg) + (P_W'(m2_yhi_reg) << GW);
    assign mag_x  = MX_W'(full_x[P_W-1:qdf_pkg::FRAC_SHIFT]);
    assign mag_y  = MX_W'(full_y[P_W-1:qdf_pkg::FRAC_SHIFT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg    <= 1'b0;
            m2_valid_reg    <= 1'b0;
            force_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg    <= rv_c[W];
            m2_valid_reg    <= m1_valid_reg;
            force_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_flags_reg <= fin_item[ITEM_W-1:ITEM_W-3];
            m1_mag_reg   <= mag;
            m1_px_reg    <= PX_W'(fin_item[GW-1:0]) * PX_W'(fin_item[GW+W +: W]);
            m1_py_reg    <= PX_W'(fin_item[GW-1:0]) * PX_W'(fin_item[GW +: W]);

            m2_flags_reg <= m1_flags_reg;
            m2_xlo_reg   <= PX_W'(m1_px_reg[GW-1:0]) * PX_W'(m1_mag_reg);
            m2_xhi_reg   <= SQ_W'(m1_px_reg[PX_W-1:GW]) * SQ_W'(m1_mag_reg);
            m2_ylo_reg   <= PX_W'(m1_py_reg[GW-1:0]) * PX_W'(m1_mag_reg);
            m2_yhi_reg   <= SQ_W'(m1_py_reg[PX_W-1:GW]) * SQ_W'(m1_mag_reg);

            force_x_reg  <= m2_flags_reg[2] ? '0 : sat_force(mag_x, m2_flags_reg[1]);
            force_y_reg  <= m2_flags_reg[2] ? '0 : sat_force(mag_y, m2_flags_reg[0]);
        end
    end

    assign force_valid = force_valid_reg;
    assign force_x     = force_x_reg;
    assign force_y     = force_y_reg;

endmodule

`default_nettype wire

// ----- rtl/core/qdf_checker.sv -----
`default_nettype none

module qdf_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cell_stall,
    input wire logic                          force_valid,
    input wire logic                          force_stall,
    input wire logic [qdf_pkg::FORCE_W-1:0]   force_x,
    input wire logic [qdf_pkg::FORCE_W-1:0]   force_y,
    input wire logic                          cfg_ready
);

    // a held result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        force_valid && force_stall |=> force_valid)
        else $error("force_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        force_valid && force_stall |=> $stable(force_x) && $stable(force_y))
        else $error("force payload changed while stalled");

    // input backpressure only comes from a result blocked at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> force_valid)
        else $error("cell_stall without a pending result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind quadratic_drag_force qdf_checker u_qdf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cell_stall  (cell_stall),
    .force_valid (force_valid),
    .force_stall (force_stall),
    .force_x     (force_x),
    .force_y     (force_y),
    .cfg_ready   (cfg_ready)
);

`default_nettype wire
